// ===== design/dpss_pkg.sv =====
`default_nettype none
package dpss_pkg;

	localparam int KICK_PHASES_DEF = 4;

	localparam int NORMAL_KICK_MS  = 23;
	localparam int SUP_KICK_MS     = 256;
	localparam int SWITCH_PAUSE_MS = 1000;

	localparam int IN_W      = 176;
	localparam int OUT_W     = 40;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_PAUSE = 2'd2;

	localparam logic [1:0] STAT_STOPPED  = 2'd0;
	localparam logic [1:0] STAT_RUNNING  = 2'd1;
	localparam logic [1:0] STAT_REJECTED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_PA  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DUTY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAFT_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODE   = 3'd5;

	// pump sequence state
	typedef enum logic [7:0] {
		ST_IDLE        = 8'b0000_0001,
		ST_HIGH_KICK   = 8'b0000_0010,
		ST_HIGH_RUN    = 8'b0000_0100,
		ST_LOW_KICK    = 8'b0000_1000,
		ST_LOW_RUN     = 8'b0001_0000,
		ST_SWITCH_WAIT = 8'b0010_0000,
		ST_SUP_KICK    = 8'b0100_0000,
		ST_SUP_RUN     = 8'b1000_0000
	} ctl_state_t;

	// request sequencer state
	typedef enum logic [4:0] {
		SQ_IDLE = 5'b00001,
		SQ_CMD  = 5'b00010,
		SQ_STEP = 5'b00100,
		SQ_KICK = 5'b01000,
		SQ_DONE = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic capture;
		logic run_cmd;
		logic run_step;
		logic run_kick;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic to_step;
		logic need_kick;
		logic kick_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== design/dpss_ctrl.sv =====
`default_nettype none
module dpss_ctrl
	import dpss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	seq_state_t state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = SQ_CMD;
				end
			end
			SQ_CMD: begin
				cmd.run_cmd = 1'b1;
				state_d     = stat.to_step ? SQ_STEP : SQ_DONE;
			end
			SQ_STEP: begin
				cmd.run_step = 1'b1;
				state_d      = stat.need_kick ? SQ_KICK : SQ_DONE;
			end
			SQ_KICK: begin
				// one kick phase per cycle until caught up
				cmd.run_kick = 1'b1;
				if (stat.kick_done) state_d = SQ_DONE;
			end
			SQ_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == SQ_IDLE);
	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

// ===== design/dpss_dp.sv =====
`default_nettype none
module dpss_dp
	import dpss_pkg::*;
#(
	parameter int KICK_PHASES = KICK_PHASES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	input  wire logic [IN_W-1:0]      s_tdata,
	input  wire logic [1:0]           s_tuser,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output logic [OUT_W-1:0]          m_tdata
);

	localparam int PHASE_W   = $clog2(KICK_PHASES);
	localparam int NORM_BASE = NORMAL_KICK_MS / KICK_PHASES;
	localparam int NORM_REM  = NORMAL_KICK_MS % KICK_PHASES;
	localparam int SUP_BASE  = SUP_KICK_MS / KICK_PHASES;
	localparam int SUP_REM   = SUP_KICK_MS % KICK_PHASES;
	localparam logic [PHASE_W-1:0] PH_LAST = PHASE_W'(KICK_PHASES - 1);

	function automatic logic [31:0] phase_len(input logic sup, input logic [PHASE_W-1:0] ph);
		logic [31:0]        base;
		logic [PHASE_W-1:0] rem;
		base = sup ? 32'(SUP_BASE) : 32'(NORM_BASE);
		rem  = sup ? PHASE_W'(SUP_REM) : PHASE_W'(NORM_REM);
		return base + {31'd0, (ph < rem)};
	endfunction

	// configuration
	logic [31:0] sw_pa_q, max_tgt_q;
	logic [15:0] start_duty_q, full_duty_q;
	logic [7:0]  raft_code_q, max_mode_q;

	// captured request
	logic [1:0]  op_q;
	logic [31:0] now_q, total_q, gauge_q, tare_q, target_q;
	logic        allowed_q, tare_ok_q;
	logic [7:0]  mode_q;

	// sequence state
	ctl_state_t         st_q, st_d;
	logic [PHASE_W-1:0] ph_q, ph_d;
	logic [31:0]        dl_q, dl_d, tgt_q, tgt_d;
	logic [7:0]         md_q, md_d;
	logic               run_q, run_d;
	logic [15:0]        low_q, low_d, high_q, high_d;
	logic               rej_q, rej_d;

	// result register
	logic [15:0] out_low_q, out_high_q;
	logic        out_run_q;
	logic [1:0]  out_stat_q;

	logic [31:0]        diff;
	logic               due, raft, reached, start_ok;
	logic               kick_high, kick_sup;
	logic [PHASE_W-1:0] ph_nx;
	logic [15:0]        kick_duty;
	logic               halt_c, bk;
	ctl_state_t         bk_st;
	logic               bk_high, bk_sup;

	assign diff      = now_q - dl_q;
	assign due       = !diff[31];
	assign raft      = (md_q == raft_code_q);
	assign reached   = (total_q >= tgt_q);
	assign start_ok  = allowed_q && (target_q != 32'd0) && (target_q <= max_tgt_q) &&
	                   (mode_q <= max_mode_q) && tare_ok_q;
	assign kick_high = (st_q != ST_LOW_KICK);
	assign kick_sup  = (st_q == ST_SUP_KICK);
	assign ph_nx     = ph_q + PHASE_W'(1);
	assign kick_duty = (ph_nx != PH_LAST) ? start_duty_q : 16'd0;

	assign stat.to_step   = (op_q == OP_TICK) || ((op_q == OP_START) && start_ok);
	assign stat.need_kick = allowed_q && run_q && !reached &&
	                        ((raft && (st_q == ST_LOW_KICK || st_q == ST_SUP_KICK)) ||
	                         (!raft && st_q == ST_HIGH_KICK));
	assign stat.kick_done = !due || (ph_q == PH_LAST);

	always_comb begin
		st_d    = st_q;
		ph_d    = ph_q;
		dl_d    = dl_q;
		tgt_d   = tgt_q;
		md_d    = md_q;
		run_d   = run_q;
		low_d   = low_q;
		high_d  = high_q;
		rej_d   = rej_q;
		halt_c  = 1'b0;
		bk      = 1'b0;
		bk_st   = ST_HIGH_KICK;
		bk_high = 1'b1;
		bk_sup  = 1'b0;

		if (cmd.run_cmd) begin
			rej_d = 1'b0;
			case (op_q)
				OP_START: begin
					if (!allowed_q) begin
						run_d  = 1'b0;
						halt_c = 1'b1;
					end
					if (start_ok) begin
						tgt_d  = target_q + tare_q;
						md_d   = mode_q;
						run_d  = 1'b1;
						halt_c = 1'b1;
					end else begin
						rej_d = 1'b1;
					end
				end
				OP_PAUSE: begin
					run_d  = 1'b0;
					halt_c = 1'b1;
				end
				default: ;
			endcase
		end

		if (cmd.run_step) begin
			if (!allowed_q || !run_q || reached) begin
				run_d  = 1'b0;
				halt_c = 1'b1;
			end else if (raft) begin
				case (st_q)
					ST_IDLE: begin
						bk = 1'b1;
						if (gauge_q <= sw_pa_q) begin
							bk_st   = ST_LOW_KICK;
							bk_high = 1'b0;
						end else begin
							bk_st  = ST_SUP_KICK;
							bk_sup = 1'b1;
						end
					end
					ST_LOW_KICK, ST_SUP_KICK: ;
					ST_LOW_RUN: begin
						if (gauge_q > sw_pa_q) begin
							low_d  = 16'd0;
							high_d = 16'd0;
							st_d   = ST_SWITCH_WAIT;
							dl_d   = now_q + 32'(SWITCH_PAUSE_MS);
						end else begin
							low_d  = full_duty_q;
							high_d = 16'd0;
						end
					end
					ST_SWITCH_WAIT: begin
						low_d  = 16'd0;
						high_d = 16'd0;
						if (due) begin
							bk     = 1'b1;
							bk_st  = ST_SUP_KICK;
							bk_sup = 1'b1;
						end
					end
					ST_SUP_RUN: begin
						low_d  = 16'd0;
						high_d = full_duty_q;
					end
					default: halt_c = 1'b1;
				endcase
			end else begin
				case (st_q)
					ST_IDLE:      bk = 1'b1;
					ST_HIGH_KICK: ;
					ST_HIGH_RUN: begin
						low_d  = 16'd0;
						high_d = full_duty_q;
					end
					default: halt_c = 1'b1;
				endcase
			end
		end

		if (cmd.run_kick && due) begin
			if (ph_q != PH_LAST) begin
				ph_d   = ph_nx;
				dl_d   = dl_q + phase_len(kick_sup, ph_nx);
				low_d  = kick_high ? 16'd0 : kick_duty;
				high_d = kick_high ? kick_duty : 16'd0;
			end else begin
				low_d  = kick_high ? 16'd0 : full_duty_q;
				high_d = kick_high ? full_duty_q : 16'd0;
				st_d   = kick_sup ? ST_SUP_RUN : (kick_high ? ST_HIGH_RUN : ST_LOW_RUN);
			end
		end

		// first phase always drives start duty (at least two phases)
		if (bk) begin
			st_d   = bk_st;
			ph_d   = '0;
			dl_d   = now_q + phase_len(bk_sup, '0);
			low_d  = bk_high ? 16'd0 : start_duty_q;
			high_d = bk_high ? start_duty_q : 16'd0;
		end

		if (halt_c) begin
			st_d   = ST_IDLE;
			ph_d   = '0;
			dl_d   = 32'd0;
			low_d  = 16'd0;
			high_d = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_pa_q      <= 32'd0;
			max_tgt_q    <= 32'd0;
			start_duty_q <= 16'd0;
			full_duty_q  <= 16'hFFFF;
			raft_code_q  <= 8'd0;
			max_mode_q   <= 8'd1;
			st_q         <= ST_IDLE;
			ph_q         <= '0;
			dl_q         <= 32'd0;
			tgt_q        <= 32'd0;
			md_q         <= 8'd0;
			run_q        <= 1'b0;
			low_q        <= 16'd0;
			high_q       <= 16'd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SWITCH_PA:  sw_pa_q      <= cfg_data;
					CFG_MAX_TARGET: max_tgt_q    <= cfg_data;
					CFG_START_DUTY: start_duty_q <= cfg_data[15:0];
					CFG_FULL_DUTY:  full_duty_q  <= cfg_data[15:0];
					CFG_RAFT_MODE:  raft_code_q  <= cfg_data[7:0];
					CFG_MAX_MODE:   max_mode_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			st_q   <= st_d;
			ph_q   <= ph_d;
			dl_q   <= dl_d;
			tgt_q  <= tgt_d;
			md_q   <= md_d;
			run_q  <= run_d;
			low_q  <= low_d;
			high_q <= high_d;
		end
	end

	always_ff @(posedge clk) begin
		rej_q <= rej_d;
		if (cmd.capture) begin
			op_q      <= s_tuser;
			now_q     <= s_tdata[31:0];
			total_q   <= s_tdata[63:32];
			gauge_q   <= s_tdata[95:64];
			allowed_q <= s_tdata[96];
			tare_ok_q <= s_tdata[97];
			tare_q    <= s_tdata[129:98];
			target_q  <= s_tdata[161:130];
			mode_q    <= s_tdata[169:162];
		end
		if (cmd.load_out) begin
			out_low_q  <= low_q;
			out_high_q <= high_q;
			out_run_q  <= run_q;
			out_stat_q <= rej_q ? STAT_REJECTED : (run_q ? STAT_RUNNING : STAT_STOPPED);
		end
	end

	assign m_tdata = {5'd0, out_stat_q, out_run_q, out_high_q, out_low_q};

endmodule
`default_nettype wire

// ===== design/dual_pump_soft_start_sequencer.sv =====
`default_nettype none
// Soft-start sequencer for a low-pressure and a high-pressure pump.
// Input stream (s_*): one request per item; s_tuser carries the opcode
// (tick, start, pause). Output stream (m_*): exactly one result per request
// with both pump duties, the running flag and a command status.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only while
// no request is in flight.
// Timing: one request at a time. A request for pause, reject or ignored opcode
// passes capture, command and result load; a control step outside a kick adds
// the step state. A step during a kick adds the kick iteration of the datapath,
// one phase per cycle while the next phase is due, advancing up to
// KICK_PHASES - 1 phases. s_tready rises again the cycle after the result is
// registered.
// Stall: the finished result sits in the output register; the next request is
// accepted and processed, and waits only for that register to free up.
// Reset: asynchronous, active low; configuration returns to its defaults, the
// sequence goes idle with both duties zero and pumping disabled.
module dual_pump_soft_start_sequencer
	import dpss_pkg::*;
#(
	parameter int KICK_PHASES = KICK_PHASES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// now_ms, total_pressure_pa, gauge_pressure_pa, motor_allowed, tare_ready,
	// tare_pa, start target, mode, zero fill
	input  wire logic [IN_W-1:0]      s_tdata,
	// opcode
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// low_pump_duty, high_pump_duty, pump_running, command_status, zero fill
	output logic [OUT_W-1:0]          m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	dpss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	dpss_dp #(
		.KICK_PHASES(KICK_PHASES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// the two pumps are never driven together
	a_one_pump: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !((m_tdata[15:0] != 16'd0) && (m_tdata[31:16] != 16'd0)))
		else $error("both pumps driven");

	// stopped means both duties are zero
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[32] |-> (m_tdata[31:0] == 32'd0))
		else $error("pump driven while not running");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:33] <= STAT_REJECTED))
		else $error("illegal command status");

endmodule
`default_nettype wire
